FILE: design/pbd_pkg.sv
// pbd_pkg: widths, constants and shared types of the pulse beat detector
// used by every design file through scoped names; depends on nothing
package pbd_pkg;

  // field and state widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned IV_W     = 16;
  localparam int unsigned BPM_W    = 8;

  // interval history
  localparam int unsigned HIST_DEPTH = 10;
  localparam int unsigned SUM_W      = IV_W + $clog2(HIST_DEPTH);

  // rate divider
  localparam int unsigned DIV_W     = IV_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // reset values and detection constants
  localparam int unsigned CFG_INIT   = 2;
  localparam int unsigned LEVEL_MID  = 512;
  localparam int unsigned THR_INIT   = 525;
  localparam int unsigned IV_INIT    = 600;
  localparam int unsigned REFRACT_MS = 250;
  localparam int unsigned TIMEOUT_MS = 2500;
  localparam int unsigned RATE_NUM   = 60000;
  localparam int unsigned BLANK_DIV  = 5;
  localparam int unsigned BLANK_MUL  = 3;
  localparam int unsigned BLANK_INIT = (IV_INIT / BLANK_DIV) * BLANK_MUL;
  localparam int unsigned BPM_SAT    = 255;

  // reciprocal multiply for the history mean, exact over the sum width
  localparam int unsigned MEAN_SHIFT  = SUM_W + $clog2(HIST_DEPTH);
  localparam int unsigned MEAN_RECIP  = ((1 << MEAN_SHIFT) + HIST_DEPTH - 1) / HIST_DEPTH;
  localparam int unsigned MEAN_PROD_W = SUM_W + MEAN_SHIFT;

  // reciprocal multiply for the blanking fifth, exact over the interval width
  localparam int unsigned BLANK_SHIFT  = IV_W + $clog2(BLANK_DIV);
  localparam int unsigned BLANK_RECIP  = ((1 << BLANK_SHIFT) + BLANK_DIV - 1) / BLANK_DIV;
  localparam int unsigned BLANK_PROD_W = IV_W + BLANK_SHIFT;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    clock_step;
    logic    since_calc;
    logic    update;
    logic    div_start;
    logic    mean_load;
    logic    bpm_load;
    logic    blank_load;
    logic    out_load;
  } pbd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic beat;
    logic counted;
    logic div_done;
    logic div_busy;
  } pbd_stat_t;

endpackage

FILE: design/pulse_beat_detector_top.sv
// Pulse beat detector: takes one 10-bit sensor sample per input word and
// returns one result word. A sample with no beat steps through the clock,
// since, update and finish states. A sample that finds the first beat after
// reset or timeout adds a state to recompute the blanking window; a counted
// beat adds the history mean (reciprocal multiply), 60000 / mean on the
// bit-serial divider and the blanking window. While the previous result word
// still waits on out_ready, the finish state holds. A new sample is taken
// while the previous result still waits in the output register. The sample
// interval register may be written at any time the block is idle; cfg_ready
// is always high.
// depends on pbd_pkg, pbd_ctrl and pbd_datapath
module pulse_beat_detector_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pbd_pkg::SAMPLE_W-1:0] sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        beat_found,
  output logic                        pulse_active,
  output logic [pbd_pkg::BPM_W-1:0]    bpm,
  output logic [pbd_pkg::IV_W-1:0]     ibi
);

  pbd_pkg::pbd_cmd_t  cmd;
  pbd_pkg::pbd_stat_t stat;

  assign cfg_ready = 1'b1;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .stat         (stat),
    .beat_found   (beat_found),
    .pulse_active (pulse_active),
    .bpm          (bpm),
    .ibi          (ibi)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  // no new sample while a division is running
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.div_busy)
    else $error("input ready while divider busy");

  // a counted beat always follows the refractory window
  a_beat_interval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beat_found) |-> (ibi > pbd_pkg::IV_W'(pbd_pkg::REFRACT_MS)))
    else $error("counted beat with too short an interval");

  // one sample at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !in_ready)
    else $error("input ready right after a word was taken");

endmodule

FILE: design/pbd_div.sv
// pbd_div: restoring unsigned divider, one quotient bit per cycle
// uses widths from pbd_pkg
module pbd_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pbd_pkg::DIV_W-1:0] dividend,
  input  logic [pbd_pkg::DIV_W-1:0] divisor,
  output logic [pbd_pkg::DIV_W-1:0] quotient,
  output logic                     done,
  output logic                     busy
);

  logic [pbd_pkg::DIV_CNT_W-1:0] count;
  logic [pbd_pkg::DIV_W-1:0]     rem;
  logic [pbd_pkg::DIV_W-1:0]     quo;
  logic [pbd_pkg::DIV_W-1:0]     dvs;
  logic [pbd_pkg::DIV_W:0]       trial;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[pbd_pkg::DIV_W-1]} - {1'b0, dvs};

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= pbd_pkg::DIV_CNT_W'(pbd_pkg::DIV_W);
      end else if (count != '0) begin
        count <= count - pbd_pkg::DIV_CNT_W'(1);
        if (count == pbd_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      if (!trial[pbd_pkg::DIV_W]) begin
        rem <= trial[pbd_pkg::DIV_W-1:0];
        quo <= {quo[pbd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[pbd_pkg::DIV_W-2:0], quo[pbd_pkg::DIV_W-1]};
        quo <= {quo[pbd_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign busy     = (count != '0);

endmodule

FILE: design/pbd_datapath.sv
// pbd_datapath: clock, level tracking, beat decision, interval history and rate
// depends on pbd_pkg and pbd_div
module pbd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [pbd_pkg::CFG_W-1:0]    cfg_data,
  input  logic [pbd_pkg::SAMPLE_W-1:0] sample,
  input  pbd_pkg::pbd_cmd_t           cmd,
  output pbd_pkg::pbd_stat_t          stat,
  output logic                        beat_found,
  output logic                        pulse_active,
  output logic [pbd_pkg::BPM_W-1:0]    bpm,
  output logic [pbd_pkg::IV_W-1:0]     ibi
);

  // state registers
  logic [pbd_pkg::CFG_W-1:0]    interval_cfg;
  logic [pbd_pkg::SAMPLE_W-1:0] sample_q;
  logic [pbd_pkg::TIME_W-1:0]   elapsed;
  logic [pbd_pkg::TIME_W-1:0]   last_beat;
  logic [pbd_pkg::TIME_W-1:0]   since;
  logic [pbd_pkg::IV_W-1:0]     interval;
  logic [pbd_pkg::IV_W-1:0]     blank;
  logic [pbd_pkg::SAMPLE_W-1:0] peak;
  logic [pbd_pkg::SAMPLE_W-1:0] trough;
  logic [pbd_pkg::SAMPLE_W-1:0] thresh;
  logic                        in_pulse;
  logic                        await_first;
  logic                        await_second;
  logic                        found;
  logic [pbd_pkg::BPM_W-1:0]    rate;
  logic [pbd_pkg::IV_W-1:0]     mean;
  logic [pbd_pkg::IV_W-1:0]     hist [pbd_pkg::HIST_DEPTH];
  logic [pbd_pkg::SUM_W-1:0]    hist_sum;

  // update terms
  logic                        below;
  logic                        above;
  logic                        past_blank;
  logic                        beat;
  logic                        early;
  logic                        counted;
  logic                        fill;
  logic                        pulse_end;
  logic                        timeout;
  logic [pbd_pkg::SAMPLE_W-1:0] trough_a;
  logic [pbd_pkg::SAMPLE_W-1:0] peak_a;
  logic [pbd_pkg::SAMPLE_W-1:0] amp;
  logic [pbd_pkg::SAMPLE_W-1:0] thresh_e;
  logic [pbd_pkg::SAMPLE_W-1:0] peak_next;
  logic [pbd_pkg::SAMPLE_W-1:0] trough_next;
  logic [pbd_pkg::SAMPLE_W-1:0] thresh_next;
  logic [pbd_pkg::IV_W-1:0]     iv_new;

  // constant divisions by reciprocal multiply
  logic [pbd_pkg::MEAN_PROD_W-1:0]  mean_prod;
  logic [pbd_pkg::BLANK_PROD_W-1:0] blank_prod;
  logic [pbd_pkg::IV_W-1:0]         blank_q;

  // divider operands
  logic [pbd_pkg::DIV_W-1:0]    div_a;
  logic [pbd_pkg::DIV_W-1:0]    div_b;
  logic [pbd_pkg::DIV_W-1:0]    div_q;
  logic                        div_done;
  logic                        div_busy;

  // sample interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_cfg <= pbd_pkg::CFG_W'(pbd_pkg::CFG_INIT);
    end else if (cfg_valid) begin
      interval_cfg <= cfg_data;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_q <= sample;
    end
  end

  // level tracking and beat decision
  always_comb begin
    below      = sample_q < thresh;
    above      = sample_q > thresh;
    past_blank = since > pbd_pkg::TIME_W'(blank);
    trough_a   = (below && past_blank && (sample_q < trough)) ? sample_q : trough;
    peak_a     = (above && (sample_q > peak)) ? sample_q : peak;
    beat       = (since > pbd_pkg::TIME_W'(pbd_pkg::REFRACT_MS)) && above && !in_pulse
                 && past_blank;
    early      = beat && await_first;
    counted    = beat && !await_first;
    fill       = beat && await_second;
    pulse_end  = below && in_pulse;
    timeout    = !early && (since > pbd_pkg::TIME_W'(pbd_pkg::TIMEOUT_MS));
    amp        = peak_a - trough_a;
    thresh_e   = (amp >> 1) + trough_a;
    iv_new     = since[pbd_pkg::IV_W-1:0];
    if (timeout) begin
      peak_next   = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      trough_next = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      thresh_next = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
    end else if (pulse_end) begin
      peak_next   = thresh_e;
      trough_next = thresh_e;
      thresh_next = thresh_e;
    end else begin
      peak_next   = peak_a;
      trough_next = trough_a;
      thresh_next = thresh;
    end
  end

  // history mean and interval fifth
  assign mean_prod  = pbd_pkg::MEAN_PROD_W'(hist_sum)
                      * pbd_pkg::MEAN_PROD_W'(pbd_pkg::MEAN_RECIP);
  assign blank_prod = pbd_pkg::BLANK_PROD_W'(interval)
                      * pbd_pkg::BLANK_PROD_W'(pbd_pkg::BLANK_RECIP);
  assign blank_q    = blank_prod[pbd_pkg::BLANK_SHIFT +: pbd_pkg::IV_W];

  // clock, levels and beat flags
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed      <= '0;
      last_beat    <= '0;
      since        <= '0;
      interval     <= pbd_pkg::IV_W'(pbd_pkg::IV_INIT);
      blank        <= pbd_pkg::IV_W'(pbd_pkg::BLANK_INIT);
      peak         <= pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      trough       <= pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      thresh       <= pbd_pkg::SAMPLE_W'(pbd_pkg::THR_INIT);
      in_pulse     <= 1'b0;
      await_first  <= 1'b1;
      await_second <= 1'b0;
      found        <= 1'b0;
      rate         <= '0;
    end else begin
      if (cmd.clock_step) begin
        elapsed <= elapsed + pbd_pkg::TIME_W'(interval_cfg);
      end
      if (cmd.since_calc) begin
        since <= elapsed - last_beat;
      end
      if (cmd.update) begin
        peak         <= peak_next;
        trough       <= trough_next;
        thresh       <= thresh_next;
        in_pulse     <= (in_pulse || beat) && !pulse_end;
        await_first  <= timeout || (await_first && !beat);
        await_second <= !timeout && (beat ? await_first : await_second);
        found        <= counted;
        if (beat || timeout) begin
          last_beat <= elapsed;
        end
        if (beat) begin
          interval <= iv_new;
        end
      end
      if (cmd.bpm_load) begin
        rate <= (mean == '0) ? pbd_pkg::BPM_W'(pbd_pkg::BPM_SAT)
                             : div_q[pbd_pkg::BPM_W-1:0];
      end
      if (cmd.blank_load) begin
        blank <= blank_q + (blank_q << 1);
      end
    end
  end

  // interval history and its running sum
  always_ff @(posedge clk) begin
    if (cmd.update && counted) begin
      for (int i = 0; i < pbd_pkg::HIST_DEPTH - 1; i++) begin
        hist[i] <= fill ? iv_new : hist[i+1];
      end
      hist[pbd_pkg::HIST_DEPTH-1] <= iv_new;
      if (fill) begin
        hist_sum <= pbd_pkg::SUM_W'(iv_new) * pbd_pkg::SUM_W'(pbd_pkg::HIST_DEPTH);
      end else begin
        hist_sum <= hist_sum - pbd_pkg::SUM_W'(hist[0]) + pbd_pkg::SUM_W'(iv_new);
      end
    end
    if (cmd.mean_load) begin
      mean <= mean_prod[pbd_pkg::MEAN_SHIFT +: pbd_pkg::IV_W];
    end
  end

  // divider operands: 60000 over the history mean
  assign div_a = pbd_pkg::DIV_W'(pbd_pkg::RATE_NUM);
  assign div_b = pbd_pkg::DIV_W'(mean);

  pbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done),
    .busy     (div_busy)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      beat_found   <= found;
      pulse_active <= in_pulse;
      bpm          <= rate;
      ibi          <= interval;
    end
  end

  assign stat.beat     = beat;
  assign stat.counted  = counted;
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;

endmodule

FILE: design/pbd_ctrl.sv
// pbd_ctrl: sequencing state machine of the pulse beat detector
// depends on pbd_pkg for command and status types
module pbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pbd_pkg::pbd_stat_t stat,
  output pbd_pkg::pbd_cmd_t  cmd
);

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b0_0000_0001,
    ST_CLOCK      = 9'b0_0000_0010,
    ST_SINCE      = 9'b0_0000_0100,
    ST_UPDATE     = 9'b0_0000_1000,
    ST_MEAN       = 9'b0_0001_0000,
    ST_RATE_GO    = 9'b0_0010_0000,
    ST_RATE_WAIT  = 9'b0_0100_0000,
    ST_BLANK      = 9'b0_1000_0000,
    ST_FINISH     = 9'b1_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CLOCK;
        end
      end
      ST_CLOCK: begin
        cmd.clock_step = 1'b1;
        state_next     = ST_SINCE;
      end
      ST_SINCE: begin
        cmd.since_calc = 1'b1;
        state_next     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        priority if (stat.counted) begin
          state_next = ST_MEAN;
        end else if (stat.beat) begin
          state_next = ST_BLANK;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MEAN: begin
        cmd.mean_load = 1'b1;
        state_next    = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (stat.div_done) begin
          cmd.bpm_load = 1'b1;
          state_next   = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.blank_load = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for pulse_beat_detector_top; holds the beat
// predictor class, the word drivers, the result monitor and a stall watchdog
// depends on pbd_pkg and pulse_beat_detector_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_MAX = (1 << pbd_pkg::SAMPLE_W) - 1;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASE_WORDS = 120;

  typedef struct packed {
    logic                      found;
    logic                      active;
    logic [pbd_pkg::BPM_W-1:0] bpm;
    logic [pbd_pkg::IV_W-1:0]  ibi;
  } beat_word_t;

  typedef enum {SEG_BEAT, SEG_NOISE, SEG_FLAT, SEG_CHATTER} segment_e;
  typedef enum {RX_OPEN, RX_SPOTTY, RX_HELD} rx_mode_e;

  // beat tracker prediction and the queue of result words it expects
  class beat_checker;
    logic [pbd_pkg::CFG_W-1:0]    step_ms;
    logic [pbd_pkg::TIME_W-1:0]   clock_ms;
    logic [pbd_pkg::TIME_W-1:0]   beat_ms;
    logic [pbd_pkg::IV_W-1:0]     ibi_ms;
    logic [pbd_pkg::SAMPLE_W-1:0] peak;
    logic [pbd_pkg::SAMPLE_W-1:0] trough;
    logic [pbd_pkg::SAMPLE_W-1:0] thresh;
    logic                         pulse;
    logic                         hunting;
    logic                         seeding;
    logic [pbd_pkg::IV_W-1:0]     history [pbd_pkg::HIST_DEPTH];
    logic [pbd_pkg::BPM_W-1:0]    rate;
    beat_word_t                   predicted_words [$];
    int unsigned                  errors;

    function new();
      step_ms  = pbd_pkg::CFG_W'(pbd_pkg::CFG_INIT);
      clock_ms = '0;
      beat_ms  = '0;
      ibi_ms   = pbd_pkg::IV_W'(pbd_pkg::IV_INIT);
      peak     = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      trough   = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
      thresh   = pbd_pkg::SAMPLE_W'(pbd_pkg::THR_INIT);
      pulse    = 1'b0;
      hunting  = 1'b1;
      seeding  = 1'b0;
      foreach (history[i]) history[i] = '0;
      rate     = '0;
      errors   = 0;
    endfunction

    function void set_interval(logic [pbd_pkg::CFG_W-1:0] v);
      step_ms = v;
    endfunction

    function int unsigned pending();
      return predicted_words.size();
    endfunction

    // advance the tracker by one sample and queue the word it should give
    function void note_sample(logic [pbd_pkg::SAMPLE_W-1:0] s);
      beat_word_t                   w;
      logic [pbd_pkg::TIME_W-1:0]   since;
      logic [pbd_pkg::TIME_W-1:0]   blank;
      logic [31:0]                  sum;
      logic [31:0]                  mean;
      logic [pbd_pkg::SAMPLE_W-1:0] swing;
      logic                         early;
      int                           i;
      w.found = 1'b0;
      early = 1'b0;
      clock_ms = clock_ms + pbd_pkg::TIME_W'(step_ms);
      since = clock_ms - beat_ms;
      blank = (ibi_ms / pbd_pkg::BLANK_DIV) * pbd_pkg::BLANK_MUL;

      // level tracking
      if (s < thresh && since > blank && s < trough) trough = s;
      if (s > thresh && s > peak) peak = s;

      // rising crossing outside the blanking window
      if (since > pbd_pkg::REFRACT_MS && s > thresh && !pulse && since > blank) begin
        pulse = 1'b1;
        ibi_ms = since[pbd_pkg::IV_W-1:0];
        beat_ms = clock_ms;
        if (seeding) begin
          seeding = 1'b0;
          foreach (history[j]) history[j] = ibi_ms;
        end
        if (hunting) begin
          hunting = 1'b0;
          seeding = 1'b1;
          early = 1'b1;
        end else begin
          sum = '0;
          for (i = 0; i < pbd_pkg::HIST_DEPTH - 1; i++) begin
            history[i] = history[i + 1];
            sum += history[i];
          end
          history[pbd_pkg::HIST_DEPTH - 1] = ibi_ms;
          sum += ibi_ms;
          mean = sum / pbd_pkg::HIST_DEPTH;
          rate = (mean == 0) ? pbd_pkg::BPM_W'(pbd_pkg::BPM_SAT)
                             : pbd_pkg::BPM_W'(pbd_pkg::RATE_NUM / mean);
          w.found = 1'b1;
        end
      end

      // pulse end moves the threshold; long silence restarts tracking
      if (!early) begin
        if (s < thresh && pulse) begin
          pulse = 1'b0;
          swing = peak - trough;
          thresh = (swing >> 1) + trough;
          peak = thresh;
          trough = thresh;
        end
        if (since > pbd_pkg::TIMEOUT_MS) begin
          thresh = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
          peak = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
          trough = pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID);
          beat_ms = clock_ms;
          hunting = 1'b1;
          seeding = 1'b0;
        end
      end

      w.active = pulse;
      w.bpm = rate;
      w.ibi = ibi_ms;
      predicted_words.push_back(w);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(beat_word_t got);
      beat_word_t want;
      if (predicted_words.size() == 0) begin
        $error("result word with no sample pending: %s=%0d %s=%0d bpm=%0d ibi=%0d",
               "beat_found", got.found, "pulse_active", got.active, got.bpm, got.ibi);
        errors++;
        return;
      end
      want = predicted_words.pop_front();
      if (got.found !== want.found) begin
        $error("beat_found mismatch: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.active !== want.active) begin
        $error("pulse_active mismatch: expected %0d, actual %0d", want.active, got.active);
        errors++;
      end
      if (got.bpm !== want.bpm) begin
        $error("bpm mismatch: expected %0d, actual %0d", want.bpm, got.bpm);
        errors++;
      end
      if (got.ibi !== want.ibi) begin
        $error("ibi mismatch: expected %0d, actual %0d", want.ibi, got.ibi);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [pbd_pkg::CFG_W-1:0]    cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [pbd_pkg::SAMPLE_W-1:0] sample;
  logic                         out_valid;
  logic                         out_ready;
  logic                         beat_found;
  logic                         pulse_active;
  logic [pbd_pkg::BPM_W-1:0]    bpm;
  logic [pbd_pkg::IV_W-1:0]     ibi;

  beat_checker chk;
  int unsigned burst_left;
  int unsigned cur_step_ms;

  pulse_beat_detector_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .beat_found   (beat_found),
    .pulse_active (pulse_active),
    .bpm          (bpm),
    .ibi          (ibi)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [pbd_pkg::SAMPLE_W-1:0] to_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return '1;
    return pbd_pkg::SAMPLE_W'(v);
  endfunction

  // one sample word, then either stay in the burst or idle for a while
  task automatic send_sample(input logic [pbd_pkg::SAMPLE_W-1:0] s);
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    chk.note_sample(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 15);
    end
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  task automatic write_interval(input logic [pbd_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    chk.set_interval(v);
    cfg_valid <= 1'b0;
    cur_step_ms = v;
  endtask

  // mostly heartbeat-shaped waveforms, with noise, silences and chatter
  task automatic play_phase(input int unsigned target);
    int unsigned sent;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    segment_e    kind;
    int          base;
    int          top;
    int          width;
    int          skew;
    int          flat_level;
    int          level;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      kind = (r < 7) ? SEG_BEAT : (r == 7) ? SEG_NOISE : (r == 8) ? SEG_FLAT : SEG_CHATTER;
      base = $urandom_range(300, 560);
      top = $urandom_range(base + 40, SAMPLE_MAX);
      flat_level = $urandom_range(0, base);
      case (kind)
        SEG_BEAT: begin
          n = (($urandom_range(0, 4) == 0) ? $urandom_range(120, 400)
                                           : $urandom_range(400, 1400)) / cur_step_ms;
          if (n < 3) n = 3;
          if (n > 120) n = 120;
        end
        SEG_NOISE: n = $urandom_range(5, 40);
        SEG_FLAT: begin
          n = pbd_pkg::TIMEOUT_MS / cur_step_ms + $urandom_range(1, 4) + 20;
          if (n > 200) n = 200;
        end
        default: n = $urandom_range(10, 30);
      endcase
      width = n / 3 + 1;
      for (k = 0; k < n; k++) begin
        case (kind)
          SEG_BEAT: begin
            if (k < width) begin
              skew = (2 * k > width) ? 2 * k - width : width - 2 * k;
              level = base + (top - base) * (width - skew) / width;
            end else begin
              level = base - int'($urandom_range(0, 30));
            end
            level = level + int'($urandom_range(0, 16)) - 8;
          end
          SEG_NOISE: level = $urandom_range(0, SAMPLE_MAX);
          SEG_FLAT: level = flat_level + int'($urandom_range(0, 4));
          default: level = k[0] ? top : int'($urandom_range(0, base));
        endcase
        send_sample(to_sample(level));
      end
      sent += n;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      chk.check_result('{beat_found, pulse_active, bpm, ibi});
    end
  end

  // receiver back-pressure: open stretches, spotty stretches, held stretches
  initial begin : receiver
    int unsigned span;
    rx_mode_e    mode;
    out_ready <= 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 2));
      span = (mode == RX_OPEN) ? $urandom_range(20, 200) : $urandom_range(1, 20);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_SPOTTY: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [pbd_pkg::CFG_W-1:0] steps [10];
    int unsigned               p;
    chk = new();
    steps = '{17, 1, 33, 500, 9, 511, 25, 2, 12, 40};
    steps[9] = pbd_pkg::CFG_W'($urandom_range(5, 60));
    cur_step_ms = pbd_pkg::CFG_INIT;
    burst_left = $urandom_range(0, 15);
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // level extremes at the reset interval, far too slow for a beat
    send_sample('0);
    send_sample('1);
    send_sample(pbd_pkg::SAMPLE_W'(pbd_pkg::THR_INIT));
    send_sample(pbd_pkg::SAMPLE_W'(pbd_pkg::THR_INIT + 1));
    send_sample(pbd_pkg::SAMPLE_W'(pbd_pkg::THR_INIT - 1));
    send_sample(pbd_pkg::SAMPLE_W'(pbd_pkg::LEVEL_MID));

    // zero interval freezes the clock
    write_interval('0);
    send_sample('1);
    send_sample('0);

    // first beat dropped, second seeds the history, third is averaged
    write_interval(pbd_pkg::CFG_W'(500));
    repeat (3) begin
      send_sample('1);
      send_sample('0);
    end

    // silence past the timeout, then the first-beat search starts over
    repeat (6) send_sample('0);
    send_sample('1);

    // random phases over a spread of sample intervals
    for (p = 0; p < 10; p++) begin
      write_interval(steps[p]);
      play_phase(PHASE_WORDS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: pulse_beat_detector_top.f
design/pbd_pkg.sv
design/pbd_div.sv
design/pbd_datapath.sv
design/pbd_ctrl.sv
design/pulse_beat_detector_top.sv
tb/tb.sv
